// ===== src/lpad_pkg.sv =====
// Shared widths, codes and reset values for the archive deframer.
// No dependencies; every other file imports this package.
`default_nettype none

package lpad_pkg;

	localparam int BYTE_W      = 8;
	localparam int PATH_LEN_W  = 16;
	localparam int FILE_SIZE_W = 32;
	localparam int HDR_W       = 32;
	localparam int HDR_IDX_W   = 2;
	localparam int KIND_W      = 2;
	localparam int ERR_W       = 2;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 32;

	localparam logic [PATH_LEN_W-1:0]  MAX_PATH_LENGTH_RESET = PATH_LEN_W'(32 * 1024);
	localparam logic [FILE_SIZE_W-1:0] MAX_FILE_SIZE_RESET   =
		FILE_SIZE_W'(64'd2 * 64'd1024 * 64'd1024 * 64'd1024);

	localparam logic [HDR_IDX_W-1:0] HDR_LAST_INDEX = HDR_IDX_W'(3);

	localparam logic [CFG_INDEX_W-1:0] REG_MAX_PATH_LENGTH = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_FILE_SIZE   = CFG_INDEX_W'(1);

	localparam logic [KIND_W-1:0] KIND_HEADER  = KIND_W'(0);
	localparam logic [KIND_W-1:0] KIND_PATH    = KIND_W'(1);
	localparam logic [KIND_W-1:0] KIND_CONTENT = KIND_W'(2);
	localparam logic [KIND_W-1:0] KIND_ERROR   = KIND_W'(3);

	localparam logic [ERR_W-1:0] ERR_NONE     = ERR_W'(0);
	localparam logic [ERR_W-1:0] ERR_BAD_PATH = ERR_W'(1);
	localparam logic [ERR_W-1:0] ERR_BAD_SIZE = ERR_W'(2);

endpackage

`default_nettype wire

// ===== src/lpad_in_if.sv =====
// Input channel of the archive deframer: one archive byte per transaction.
// Depends on lpad_pkg for the byte width.
`default_nettype none

interface lpad_in_if;
	import lpad_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] stream_byte;

	modport source (output valid, output stream_byte, input ready);
	modport sink   (input valid, input stream_byte, output ready);
endinterface

`default_nettype wire

// ===== src/lpad_out_if.sv =====
// Result channel of the archive deframer: one header, byte or error per transaction.
// Depends on lpad_pkg for field widths.
`default_nettype none

interface lpad_out_if;
	import lpad_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [KIND_W-1:0]      result_kind;
	logic [BYTE_W-1:0]      out_byte;
	logic [PATH_LEN_W-1:0]  entry_path_length;
	logic [FILE_SIZE_W-1:0] entry_file_size;
	logic                   end_of_entry;
	logic [ERR_W-1:0]       fault_code;

	modport source (output valid, output result_kind, output out_byte,
		output entry_path_length, output entry_file_size, output end_of_entry,
		output fault_code, input ready);
	modport sink   (input valid, input result_kind, input out_byte,
		input entry_path_length, input entry_file_size, input end_of_entry,
		input fault_code, output ready);
endinterface

`default_nettype wire

// ===== src/length_prefixed_archive_deframer_unit.sv =====
// Top level of the length-prefixed archive deframer.
// Depends on lpad_pkg, lpad_in_if and lpad_out_if.
`default_nettype none

// The deframer takes an archive one byte per transaction and splits it into
// entries: a little-endian 32-bit path length (nonzero, at most
// max_path_length), a little-endian 32-bit file size (at most max_file_size),
// then the path bytes and the content bytes. On the last byte of the size
// header it returns a header transaction carrying both lengths; each path and
// content byte then comes out tagged with its kind, and the final byte of the
// entry has end_of_entry set (for an empty file that is the last path byte).
// Header bytes other than the completing one return nothing. A bad length or
// size returns one error transaction and the block then swallows every byte
// until reset. Throughput is one byte per clock: each byte is decoded by the
// phase machine and its byte counters, and the result goes into one output
// register, so input stalls only while that register holds a result the sink
// has not taken. The result is valid in the cycle after its byte is accepted.
// Limits are written through cfg_we/cfg_index/cfg_data and take effect at the
// next header check; write them only while the block is idle.
module length_prefixed_archive_deframer_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lpad_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [lpad_pkg::CFG_DATA_W-1:0]   cfg_data,
	lpad_in_if.sink                           stream,
	lpad_out_if.source                        result
);
	import lpad_pkg::*;

	typedef enum logic [1:0] {
		PH_LEN,
		PH_SIZE,
		PH_PATH,
		PH_DATA
	} phase_t;

	// Configuration registers
	logic [PATH_LEN_W-1:0]  max_path_q;
	logic [FILE_SIZE_W-1:0] max_size_q;

	// Parser state
	phase_t                 phase_q;
	logic [HDR_IDX_W-1:0]   hdr_idx_q;
	logic [HDR_W-BYTE_W-1:0] hdr_shift_q;
	logic [PATH_LEN_W-1:0]  path_left_q;
	logic [PATH_LEN_W-1:0]  saved_path_q;
	logic [FILE_SIZE_W-1:0] content_left_q;
	logic                   halted_q;

	// Output register
	logic                   out_valid_q;
	logic [KIND_W-1:0]      out_kind_q;
	logic [BYTE_W-1:0]      out_byte_q;
	logic [PATH_LEN_W-1:0]  out_plen_q;
	logic [FILE_SIZE_W-1:0] out_fsize_q;
	logic                   out_last_q;
	logic [ERR_W-1:0]       out_err_q;

	// Decode of the current byte
	logic                   in_fire;
	logic [HDR_W-1:0]       hdr_word;
	logic                   hdr_done;
	logic                   len_bad;
	logic                   size_bad;
	logic                   res_valid;
	logic [KIND_W-1:0]      res_kind;
	logic [BYTE_W-1:0]      res_byte;
	logic [PATH_LEN_W-1:0]  res_plen;
	logic [FILE_SIZE_W-1:0] res_fsize;
	logic                   res_last;
	logic [ERR_W-1:0]       res_err;

	// Accept whenever the output register is free or being drained this cycle.
	assign stream.ready = !out_valid_q || result.ready;
	assign in_fire      = stream.valid && stream.ready;

	// The fourth header byte completes the word: top lane comes straight from the input.
	assign hdr_word = {stream.stream_byte, hdr_shift_q};
	assign hdr_done = (hdr_idx_q == HDR_LAST_INDEX);
	assign len_bad  = (hdr_word == '0) ||
		(hdr_word > {{(HDR_W-PATH_LEN_W){1'b0}}, max_path_q});
	assign size_bad = (hdr_word > max_size_q);

	always_comb begin
		res_valid = 1'b0;
		res_kind  = KIND_HEADER;
		res_byte  = '0;
		res_plen  = '0;
		res_fsize = '0;
		res_last  = 1'b0;
		res_err   = ERR_NONE;
		if (!halted_q) begin
			case (phase_q)
				PH_LEN: begin
					// A good path length stays silent; only a bad one reports.
					if (hdr_done && len_bad) begin
						res_valid = 1'b1;
						res_kind  = KIND_ERROR;
						res_err   = ERR_BAD_PATH;
					end
				end
				PH_SIZE: begin
					if (hdr_done) begin
						res_valid = 1'b1;
						if (size_bad) begin
							res_kind = KIND_ERROR;
							res_err  = ERR_BAD_SIZE;
						end else begin
							res_kind  = KIND_HEADER;
							res_plen  = saved_path_q;
							res_fsize = hdr_word;
						end
					end
				end
				PH_PATH: begin
					res_valid = 1'b1;
					res_kind  = KIND_PATH;
					res_byte  = stream.stream_byte;
					// Empty file: the entry closes on its last path byte.
					res_last  = (path_left_q == PATH_LEN_W'(1)) && (content_left_q == '0);
				end
				PH_DATA: begin
					res_valid = 1'b1;
					res_kind  = KIND_CONTENT;
					res_byte  = stream.stream_byte;
					res_last  = (content_left_q == FILE_SIZE_W'(1));
				end
				default: begin
					res_valid = 1'b0;
				end
			endcase
		end
	end

	// Configuration writes; indexes past the list do nothing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_path_q <= MAX_PATH_LENGTH_RESET;
			max_size_q <= MAX_FILE_SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_PATH_LENGTH: max_path_q <= cfg_data[PATH_LEN_W-1:0];
				REG_MAX_FILE_SIZE:   max_size_q <= cfg_data[FILE_SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// Phase machine, byte counters and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_LEN;
			hdr_idx_q      <= '0;
			hdr_shift_q    <= '0;
			path_left_q    <= '0;
			saved_path_q   <= '0;
			content_left_q <= '0;
			halted_q       <= 1'b0;
			out_valid_q    <= 1'b0;
			out_kind_q     <= KIND_HEADER;
			out_byte_q     <= '0;
			out_plen_q     <= '0;
			out_fsize_q    <= '0;
			out_last_q     <= 1'b0;
			out_err_q      <= ERR_NONE;
		end else begin
			// Load a new result, or drop the old one once the sink takes it.
			if (in_fire && res_valid) begin
				out_valid_q <= 1'b1;
				out_kind_q  <= res_kind;
				out_byte_q  <= res_byte;
				out_plen_q  <= res_plen;
				out_fsize_q <= res_fsize;
				out_last_q  <= res_last;
				out_err_q   <= res_err;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			if (in_fire && !halted_q) begin
				case (phase_q)
					PH_LEN, PH_SIZE: begin
						if (!hdr_done) begin
							case (hdr_idx_q)
								HDR_IDX_W'(0): hdr_shift_q[BYTE_W-1:0] <= stream.stream_byte;
								HDR_IDX_W'(1): hdr_shift_q[2*BYTE_W-1:BYTE_W] <= stream.stream_byte;
								default: hdr_shift_q[3*BYTE_W-1:2*BYTE_W] <= stream.stream_byte;
							endcase
							hdr_idx_q <= hdr_idx_q + HDR_IDX_W'(1);
						end else begin
							hdr_idx_q   <= '0;
							hdr_shift_q <= '0;
							if (phase_q == PH_LEN) begin
								if (len_bad) begin
									halted_q <= 1'b1;
								end else begin
									saved_path_q <= hdr_word[PATH_LEN_W-1:0];
									phase_q      <= PH_SIZE;
								end
							end else if (size_bad) begin
								halted_q <= 1'b1;
							end else begin
								content_left_q <= hdr_word;
								path_left_q    <= saved_path_q;
								phase_q        <= PH_PATH;
							end
						end
					end
					PH_PATH: begin
						path_left_q <= path_left_q - PATH_LEN_W'(1);
						if (path_left_q == PATH_LEN_W'(1)) begin
							phase_q <= (content_left_q == '0) ? PH_LEN : PH_DATA;
						end
					end
					PH_DATA: begin
						content_left_q <= content_left_q - FILE_SIZE_W'(1);
						if (content_left_q == FILE_SIZE_W'(1)) begin
							phase_q <= PH_LEN;
						end
					end
					default: begin
						halted_q <= 1'b1;
					end
				endcase
			end
		end
	end

	assign result.valid             = out_valid_q;
	assign result.result_kind       = out_kind_q;
	assign result.out_byte          = out_byte_q;
	assign result.entry_path_length = out_plen_q;
	assign result.entry_file_size   = out_fsize_q;
	assign result.end_of_entry      = out_last_q;
	assign result.fault_code        = out_err_q;

	// Once halted, stay halted until reset.
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("deframer left the halted state without reset");

	// A pending error result implies the parser is already halted.
	a_error_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_kind_q == KIND_ERROR)) |-> halted_q)
		else $error("error result without halt");

	// Path phase always has at least one path byte to go.
	a_path_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PATH) |-> (path_left_q != '0))
		else $error("path phase with no path bytes left");

	// A partly collected header only exists in the header phases.
	a_hdr_idx_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(hdr_idx_q != '0) |-> ((phase_q == PH_LEN) || (phase_q == PH_SIZE)))
		else $error("header byte index set outside a header phase");

endmodule

`default_nettype wire

// ===== sim/length_prefixed_archive_deframer_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench for length_prefixed_archive_deframer_unit: streams archive entries
// through the byte channel and checks every result against a local predictor.
// Depends on lpad_pkg, lpad_in_if, lpad_out_if and the deframer top level.

import lpad_pkg::*;

typedef struct packed {
	logic [KIND_W-1:0]      kind;
	logic [BYTE_W-1:0]      payload;
	logic [PATH_LEN_W-1:0]  path_len;
	logic [FILE_SIZE_W-1:0] file_size;
	logic                   eoe;
	logic [ERR_W-1:0]       err;
} deframe_rec_t;

// Tracks the deframer state, predicts the result of every accepted byte and
// matches the results that leave the block against those predictions in order.
class archive_split_checker;
	typedef enum logic [1:0] {RD_LEN, RD_SIZE, IN_PATH, IN_CONTENT} walk_t;

	walk_t                   walk;
	logic [HDR_IDX_W-1:0]    hdr_idx;
	logic [HDR_W-1:0]        hdr_shift;
	logic [PATH_LEN_W-1:0]   path_left;
	logic [PATH_LEN_W-1:0]   saved_plen;
	logic [FILE_SIZE_W-1:0]  content_left;
	logic                    halted;
	logic [PATH_LEN_W-1:0]   lim_path;
	logic [FILE_SIZE_W-1:0]  lim_size;
	deframe_rec_t            pending_results[$];
	int                      errors;

	function new();
		walk = RD_LEN;
		hdr_idx = '0;
		hdr_shift = '0;
		path_left = '0;
		saved_plen = '0;
		content_left = '0;
		halted = 1'b0;
		lim_path = MAX_PATH_LENGTH_RESET;
		lim_size = MAX_FILE_SIZE_RESET;
		errors = 0;
	endfunction

	function void configure(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		if (idx == REG_MAX_PATH_LENGTH)
			lim_path = val[PATH_LEN_W-1:0];
		else if (idx == REG_MAX_FILE_SIZE)
			lim_size = val[FILE_SIZE_W-1:0];
	endfunction

	function int pending();
		return pending_results.size();
	endfunction

	// Append one predicted result at the tail of the queue.
	function void expect_result(deframe_rec_t r);
		pending_results.insert(pending_results.size(), r);
	endfunction

	function void note_byte(logic [BYTE_W-1:0] b);
		deframe_rec_t r;
		logic [HDR_W-1:0] word;
		r = '0;
		if (halted)
			return;
		case (walk)
			RD_LEN, RD_SIZE: begin
				hdr_shift = hdr_shift | (HDR_W'(b) << (8 * hdr_idx));
				if (hdr_idx != HDR_LAST_INDEX) begin
					hdr_idx = hdr_idx + 1'b1;
					return;
				end
				word = hdr_shift;
				hdr_idx = '0;
				hdr_shift = '0;
				if (walk == RD_LEN) begin
					if (word == 0 || word > HDR_W'(lim_path)) begin
						halted = 1'b1;
						r.kind = KIND_ERROR;
						r.err = ERR_BAD_PATH;
						expect_result(r);
					end else begin
						saved_plen = word[PATH_LEN_W-1:0];
						walk = RD_SIZE;
					end
				end else if (word > lim_size) begin
					halted = 1'b1;
					r.kind = KIND_ERROR;
					r.err = ERR_BAD_SIZE;
					expect_result(r);
				end else begin
					content_left = word;
					path_left = saved_plen;
					walk = IN_PATH;
					r.kind = KIND_HEADER;
					r.path_len = saved_plen;
					r.file_size = word;
					expect_result(r);
				end
			end
			IN_PATH: begin
				path_left = path_left - 1'b1;
				r.kind = KIND_PATH;
				r.payload = b;
				if (path_left == 0) begin
					if (content_left == 0) begin
						r.eoe = 1'b1;
						walk = RD_LEN;
					end else begin
						walk = IN_CONTENT;
					end
				end
				expect_result(r);
			end
			default: begin
				content_left = content_left - 1'b1;
				r.kind = KIND_CONTENT;
				r.payload = b;
				if (content_left == 0) begin
					r.eoe = 1'b1;
					walk = RD_LEN;
				end
				expect_result(r);
			end
		endcase
	endfunction

	function void compare(string field, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		end
	endfunction

	function void check(deframe_rec_t got);
		deframe_rec_t want;
		if (pending_results.size() == 0) begin
			errors++;
			$display("%0t: unexpected result, expected none, actual %p", $time, got);
			return;
		end
		want = pending_results.pop_front();
		compare("result_kind", want.kind, got.kind);
		compare("out_byte", want.payload, got.payload);
		compare("entry_path_length", want.path_len, got.path_len);
		compare("entry_file_size", want.file_size, got.file_size);
		compare("end_of_entry", want.eoe, got.eoe);
		compare("fault_code", want.err, got.err);
	endfunction
endclass

module length_prefixed_archive_deframer_unit_tb;

	localparam int RANDOM_ITEMS = 1000;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_INDEX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;

	lpad_in_if  byte_in();
	lpad_out_if res_out();

	length_prefixed_archive_deframer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.stream    (byte_in),
		.result    (res_out)
	);

	archive_split_checker ledger = new();

	// Pacing: when set, both the byte source and the result sink pause at random
	// between transactions; when clear, both run flat out.
	bit           pace_idle;
	int unsigned  bytes_sent;
	int unsigned  cur_path_lim;
	int unsigned  cur_size_lim;
	deframe_rec_t seen;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#20_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Sample both channels at the edge; every driver uses nonblocking updates,
	// so the values seen here are the ones the block saw at this edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_in.valid && byte_in.ready)
				ledger.note_byte(byte_in.stream_byte);
			if (res_out.valid && res_out.ready) begin
				seen.kind = res_out.result_kind;
				seen.payload = res_out.out_byte;
				seen.path_len = res_out.entry_path_length;
				seen.file_size = res_out.entry_file_size;
				seen.eoe = res_out.end_of_entry;
				seen.err = res_out.fault_code;
				ledger.check(seen);
			end
		end
	end

	// Result sink: per transaction, hold ready low for a random stall, then
	// raise it and keep it up until a result is taken.
	initial begin
		int stall;
		res_out.ready <= 1'b0;
		wait (arst_n);
		forever begin
			stall = pace_idle ? $urandom_range(0, 10) : 0;
			if (stall > 0) begin
				res_out.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_out.ready <= 1'b1;
			do @(posedge clk); while (!res_out.valid);
		end
	end

	// Offer one byte after a random gap and hold it until accepted. Keep valid
	// high across back-to-back bytes so it is never dropped and raised in one step.
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int gap;
		gap = pace_idle ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			byte_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_in.valid <= 1'b1;
		byte_in.stream_byte <= b;
		do @(posedge clk); while (!byte_in.ready);
		bytes_sent++;
	endtask

	// Headers go out little-endian.
	task automatic send_word(input logic [HDR_W-1:0] w);
		for (int i = 0; i < 4; i++)
			send_byte(w[8*i +: 8]);
	endtask

	task automatic send_entry(input int unsigned plen, input int unsigned fsize);
		send_word(plen);
		send_word(fsize);
		repeat (plen) send_byte($urandom_range(0, 255));
		repeat (fsize) send_byte($urandom_range(0, 255));
	endtask

	// Drop valid, let every predicted result drain, then idle as slack behind the
	// output register. The first edge lets the monitor record the final byte
	// before the queue is polled.
	task automatic settle();
		byte_in.valid <= 1'b0;
		@(posedge clk);
		while (ledger.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Pulse one register write; the trailing edge keeps consecutive writes
	// from putting two updates on cfg_we in one step.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		ledger.configure(idx, val);
		if (idx == REG_MAX_PATH_LENGTH)
			cur_path_lim = val[PATH_LEN_W-1:0];
		else
			cur_size_lim = val;
		@(posedge clk);
	endtask

	initial begin
		int unsigned random_start;
		int unsigned plen;
		int unsigned fsize;
		int unsigned cap;
		int unsigned pick;

		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_MAX_PATH_LENGTH;
		cfg_data <= '0;
		byte_in.valid <= 1'b0;
		byte_in.stream_byte <= '0;
		pace_idle = 1'b1;
		bytes_sent = 0;
		cur_path_lim = MAX_PATH_LENGTH_RESET;
		cur_size_lim = MAX_FILE_SIZE_RESET;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset limits. Empty file first: the entry must close on its
		// only path byte. Then a short file with bytes 00, 80, 7F and FF across its parts.
		send_word(32'd1);
		send_word(32'd0);
		send_byte(8'hFF);
		send_word(32'd2);
		send_word(32'd2);
		send_byte(8'h00);
		send_byte(8'h80);
		send_byte(8'h7F);
		send_byte(8'hFF);

		// Tightest limits: one-byte paths and empty files, both at the boundary.
		settle();
		write_reg(REG_MAX_PATH_LENGTH, 1);
		write_reg(REG_MAX_FILE_SIZE, 0);
		repeat (3) send_entry(1, 0);

		// Widest size limit, path limit back to its reset value.
		settle();
		write_reg(REG_MAX_PATH_LENGTH, 32768);
		write_reg(REG_MAX_FILE_SIZE, 32'hFFFF_FFFF);
		repeat (3) send_entry($urandom_range(1, 12), $urandom_range(0, 24));

		// Random well-formed archives in groups; between groups, drain fully and
		// pick new limits, the register extremes among them.
		random_start = bytes_sent;
		while (bytes_sent - random_start < RANDOM_ITEMS) begin
			settle();
			pick = $urandom_range(0, 7);
			write_reg(REG_MAX_PATH_LENGTH, pick == 0 ? 65535 : pick == 1 ? 32768 :
				$urandom_range(1, 48));
			pick = $urandom_range(0, 7);
			write_reg(REG_MAX_FILE_SIZE, pick == 0 ? 32'hFFFF_FFFF : pick == 1 ? 0 :
				$urandom_range(0, 30));
			repeat ($urandom_range(3, 8)) begin
				pace_idle = ($urandom_range(0, 3) != 0);
				cap = cur_path_lim < 12 ? cur_path_lim : 12;
				plen = ($urandom_range(0, 7) == 0 && cur_path_lim <= 48) ?
					cur_path_lim : $urandom_range(1, cap);
				cap = cur_size_lim < 24 ? cur_size_lim : 24;
				pick = $urandom_range(0, 7);
				fsize = pick < 2 ? 0 : (pick == 2 && cur_size_lim <= 30) ?
					cur_size_lim : $urandom_range(0, cap);
				send_entry(plen, fsize);
			end
		end

		// One bad header ends the stream for good, so it goes last. Pick which
		// rejection to provoke, then push noise that must produce nothing.
		settle();
		pace_idle = 1'b1;
		pick = $urandom_range(0, 3);
		if (pick == 0) begin
			send_word(32'd0);
		end else if (pick == 1) begin
			send_word($urandom_range(0, 1) ? 32'hFFFF_FFFF : cur_path_lim + 1);
		end else if (pick == 2) begin
			// A zero path limit rejects every length.
			write_reg(REG_MAX_PATH_LENGTH, 0);
			send_word($urandom_range(1, 65535));
		end else begin
			write_reg(REG_MAX_FILE_SIZE, $urandom_range(0, 100));
			send_word($urandom_range(1, cur_path_lim < 8 ? cur_path_lim : 8));
			send_word($urandom_range(0, 1) ? 32'hFFFF_FFFF : cur_size_lim + 1);
		end
		repeat (24) send_byte($urandom_range(0, 255));

		settle();
		if (ledger.errors == 0 && ledger.pending() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
